### hdl/tcw_pkg.sv
package tcw_pkg;

	// payload field widths
	localparam int unsigned REQ_W      = 3;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned ATTR_W     = 8;
	localparam int unsigned TCOL_W     = 7;
	localparam int unsigned TROW_W     = 5;
	localparam int unsigned COL_W      = 7;
	localparam int unsigned ROW_W      = 6;
	localparam int unsigned CELL_W     = 16;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned COLS_W     = 8;
	localparam int unsigned ROWS_W     = 6;

	// default geometry limits
	localparam int unsigned DEF_MAX_COLS  = 128;
	localparam int unsigned DEF_MAX_ROWS  = 32;
	localparam int unsigned DEF_TAB_WIDTH = 4;

	// register reset values
	localparam logic [COLS_W-1:0] RESET_COLUMNS = 8'd80;
	localparam logic [ROWS_W-1:0] RESET_ROWS    = 6'd25;
	localparam logic [ATTR_W-1:0] RESET_ATTR    = 8'h07;

	// cell and character codes
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0f00;
	localparam logic [CELL_W-1:0] CLEAR_CELL = 16'h0000;
	localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NL      = 8'h0a;
	localparam logic [CHAR_W-1:0] CH_ESC     = 8'h1b;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b1;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUT   = 3'd0,
		REQ_CLEAR = 3'd1,
		REQ_LEFT  = 3'd2,
		REQ_RIGHT = 3'd3,
		REQ_UP    = 3'd4,
		REQ_DOWN  = 3'd5,
		REQ_MOVE  = 3'd6,
		REQ_READ  = 3'd7
	} tcw_req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PRINT,
		ST_SCROLL,
		ST_READ,
		ST_HOLD
	} tcw_state_t;

endpackage

### hdl/tcw_req_if.sv
interface tcw_req_if import tcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [CHAR_W-1:0] char_byte;
	logic [TCOL_W-1:0] target_col;
	logic [TROW_W-1:0] target_row;

	modport source (output valid, req_type, char_byte, target_col, target_row, input ready);
	modport sink (input valid, req_type, char_byte, target_col, target_row, output ready);
endinterface

### hdl/tcw_rsp_if.sv
interface tcw_rsp_if import tcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [COL_W-1:0]  cursor_col;
	logic [ROW_W-1:0]  cursor_row;
	logic [CELL_W-1:0] cell_value;
	logic              bad_position;

	modport source (output valid, cursor_col, cursor_row, cell_value, bad_position,
		input ready);
	modport sink (input valid, cursor_col, cursor_row, cell_value, bad_position,
		output ready);
endinterface

### hdl/tcw_store.sv
module tcw_store import tcw_pkg::*; #(
	parameter int unsigned DEPTH = DEF_MAX_COLS * DEF_MAX_ROWS,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [AW-1:0]     addr,
	input  logic [CELL_W-1:0] wdata,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [DEPTH];

	// single port cell array, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

### hdl/tcw_addr.sv
module tcw_addr import tcw_pkg::*; #(
	parameter int unsigned MAX_COLS = DEF_MAX_COLS,
	parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
	parameter int unsigned RW       = $clog2(MAX_ROWS),
	parameter int unsigned AW       = $clog2(MAX_COLS * MAX_ROWS)
) (
	input  logic [RW-1:0]    top_line,
	input  logic [COL_W-1:0] col,
	input  logic [ROW_W-1:0] row,
	output logic [AW-1:0]    addr
);

	logic [ROW_W:0] sum;
	logic [ROW_W:0] prow;

	// logical row to physical ring row, then row-major cell index
	always_comb begin
		sum  = (ROW_W+1)'(top_line) + (ROW_W+1)'(row);
		prow = (sum >= (ROW_W+1)'(MAX_ROWS)) ? sum - (ROW_W+1)'(MAX_ROWS) : sum;
		addr = AW'(prow[RW-1:0]) * AW'(MAX_COLS) + AW'(col);
	end

endmodule

### hdl/text_console_writer.sv
// Text console engine: a screen of 16-bit cells (attribute above character) held in one
// single-port memory, plus cursor, current attribute and escape flag in registers. Each
// request gives one result with the cursor afterwards. Cursor moves, escape handling and a
// newline without scroll need no memory access; a printable byte and a cell read are accepted
// first, then the memory access follows; a tab prints TAB_WIDTH spaces. A scroll advances a
// ring top line and rewrites the new last line one cell a cycle. Clearing walks the whole
// store one cell a cycle, both after reset and for a clear request; no item is taken
// meanwhile, configuration writes are. A finished result sits in an output register, so the
// next item is taken while it waits.
module text_console_writer import tcw_pkg::*; #(
	parameter int unsigned MAX_COLS  = DEF_MAX_COLS,
	parameter int unsigned MAX_ROWS  = DEF_MAX_ROWS,
	parameter int unsigned TAB_WIDTH = DEF_TAB_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tcw_req_if.sink               req,
	tcw_rsp_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned RW    = $clog2(MAX_ROWS);
	localparam int unsigned CNTW  = $clog2(TAB_WIDTH + 1);
	localparam int unsigned CMAX  = (MAX_COLS < 128) ? MAX_COLS : 128;

	tcw_state_t state_q, state_d;

	logic [COLS_W-1:0] cols_q;
	logic [ROWS_W-1:0] rows_q;
	logic [RW-1:0]     top_q, top_d, top_inc;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [ATTR_W-1:0] attr_q, attr_d;
	logic              esc_q, esc_d;
	logic [CNTW-1:0]   cnt_q, cnt_d;
	logic [CHAR_W-1:0] char_q, char_d;
	logic [AW-1:0]     clr_q, clr_d;
	logic              clr_rsp_q, clr_rsp_d;
	logic [CELL_W-1:0] cell_q, cell_d;
	logic              bad_q, bad_d;

	logic              out_valid_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [CELL_W-1:0] out_cell_q;
	logic              out_bad_q;

	logic [COLS_W-1:0] c_eff;
	logic [ROWS_W-1:0] r_eff;
	logic [COL_W-1:0]  ncol;
	logic [ROW_W-1:0]  nrow;
	logic              acc, slot_free, load, good;
	logic              fin, go_print, go_scroll, go_clear, go_read, clr_done;

	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_addr, cell_addr;
	logic [CELL_W-1:0] mem_wd, mem_rd;
	logic [COL_W-1:0]  a_col;
	logic [ROW_W-1:0]  a_row;

	tcw_req_t req_code;

	assign acc       = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || rsp.ready;
	assign load      = (fin || state_q == ST_HOLD) && slot_free;
	assign req_code  = tcw_req_t'(req.req_type);

	// geometry in use, clamped
	always_comb begin
		if (cols_q == '0) begin
			c_eff = COLS_W'(1);
		end else if (cols_q > COLS_W'(CMAX)) begin
			c_eff = COLS_W'(CMAX);
		end else begin
			c_eff = cols_q;
		end
		if (rows_q == '0) begin
			r_eff = ROWS_W'(1);
		end else if ((ROWS_W+1)'(rows_q) > (ROWS_W+1)'(MAX_ROWS)) begin
			r_eff = ROWS_W'(MAX_ROWS);
		end else begin
			r_eff = rows_q;
		end
	end

	// cursor saturated to the current geometry
	always_comb begin
		ncol = ((COLS_W)'(col_q) >= c_eff) ? COL_W'(c_eff - COLS_W'(1)) : col_q;
		nrow = (row_q > r_eff) ? r_eff : row_q;
		if (nrow == r_eff) begin
			ncol = '0;
		end
	end

	assign top_inc = (top_q == RW'(MAX_ROWS - 1)) ? '0 : top_q + RW'(1);
	assign good    = ((COLS_W)'(req.target_col) < c_eff)
		&& ((ROWS_W)'(req.target_row) < r_eff);

	// cell address: request target while idle, cursor otherwise
	assign a_col    = (state_q == ST_IDLE) ? req.target_col : col_q;
	assign a_row    = (state_q == ST_IDLE) ? ROW_W'(req.target_row) : row_q;
	assign mem_addr = (state_q == ST_CLEAR) ? clr_q : cell_addr;

	tcw_addr #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS),
		.RW       (RW),
		.AW       (AW)
	) u_addr (
		.top_line (top_q),
		.col      (a_col),
		.row      (a_row),
		.addr     (cell_addr)
	);

	tcw_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wd),
		.rdata (mem_rd)
	);

	// request work and store access per state
	always_comb begin
		top_d     = top_q;
		col_d     = col_q;
		row_d     = row_q;
		attr_d    = attr_q;
		esc_d     = esc_q;
		cnt_d     = cnt_q;
		char_d    = char_q;
		clr_d     = clr_q;
		clr_rsp_d = clr_rsp_q;
		cell_d    = '0;
		bad_d     = 1'b0;
		fin       = 1'b0;
		go_print  = 1'b0;
		go_scroll = 1'b0;
		go_clear  = 1'b0;
		go_read   = 1'b0;
		clr_done  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wd    = CLEAR_CELL;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				clr_d  = clr_q + AW'(1);
				if (clr_q == AW'(DEPTH - 1)) begin
					clr_done  = 1'b1;
					fin       = clr_rsp_q;
					clr_rsp_d = 1'b0;
				end
			end
			ST_IDLE: begin
				if (acc) begin
					col_d = ncol;
					row_d = nrow;
					case (req_code)
						REQ_PUT: begin
							if (esc_q) begin
								attr_d = req.char_byte;
								esc_d  = 1'b0;
								fin    = 1'b1;
							end else if (req.char_byte == CH_ESC) begin
								esc_d = 1'b1;
								fin   = 1'b1;
							end else if (req.char_byte == CH_NL) begin
								if ((ROW_W+1)'(nrow) + (ROW_W+1)'(1) >= (ROW_W+1)'(r_eff)) begin
									go_scroll = 1'b1;
									cnt_d     = '0;
									top_d     = top_inc;
									col_d     = '0;
									row_d     = r_eff - ROW_W'(1);
								end else begin
									row_d = nrow + ROW_W'(1);
									col_d = '0;
									fin   = 1'b1;
								end
							end else if (req.char_byte == CH_TAB) begin
								cnt_d    = CNTW'(TAB_WIDTH);
								char_d   = CH_SPACE;
								go_print = 1'b1;
							end else if (req.char_byte == CH_NUL) begin
								fin = 1'b1;
							end else begin
								cnt_d    = CNTW'(1);
								char_d   = req.char_byte;
								go_print = 1'b1;
							end
						end
						REQ_CLEAR: begin
							top_d     = '0;
							col_d     = '0;
							row_d     = '0;
							clr_d     = '0;
							clr_rsp_d = 1'b1;
							go_clear  = 1'b1;
						end
						REQ_LEFT: begin
							if (nrow < r_eff && ncol != '0) begin
								col_d = ncol - COL_W'(1);
							end
							fin = 1'b1;
						end
						REQ_RIGHT: begin
							if (nrow < r_eff && (COLS_W'(ncol) + COLS_W'(1)) < c_eff) begin
								col_d = ncol + COL_W'(1);
							end
							fin = 1'b1;
						end
						REQ_UP: begin
							if (nrow != '0) begin
								row_d = nrow - ROW_W'(1);
							end
							fin = 1'b1;
						end
						REQ_DOWN: begin
							if ((ROW_W+1)'(nrow) + (ROW_W+1)'(1) < (ROW_W+1)'(r_eff)) begin
								row_d = nrow + ROW_W'(1);
							end
							fin = 1'b1;
						end
						REQ_MOVE: begin
							if (good) begin
								col_d = req.target_col;
								row_d = ROW_W'(req.target_row);
							end else begin
								bad_d = 1'b1;
							end
							fin = 1'b1;
						end
						default: begin
							if (good) begin
								mem_re  = 1'b1;
								go_read = 1'b1;
							end else begin
								bad_d = 1'b1;
								fin   = 1'b1;
							end
						end
					endcase
				end
			end
			ST_PRINT: begin
				if (row_q >= r_eff) begin
					// one past the final cell: scroll before printing
					go_scroll = 1'b1;
					top_d     = top_inc;
					col_d     = '0;
					row_d     = r_eff - ROW_W'(1);
				end else begin
					mem_we = 1'b1;
					mem_wd = {attr_q, char_q};
					if (COLS_W'(col_q) + COLS_W'(1) >= c_eff) begin
						col_d = '0;
						row_d = row_q + ROW_W'(1);
					end else begin
						col_d = col_q + COL_W'(1);
					end
					cnt_d = cnt_q - CNTW'(1);
					fin   = (cnt_q == CNTW'(1));
				end
			end
			ST_SCROLL: begin
				// blank the new last line, cursor column doubles as sweep
				mem_we = 1'b1;
				mem_wd = BLANK_CELL;
				if (COLS_W'(col_q) + COLS_W'(1) >= c_eff) begin
					col_d = '0;
					if (cnt_q != '0) begin
						go_print = 1'b1;
					end else begin
						fin = 1'b1;
					end
				end else begin
					col_d = col_q + COL_W'(1);
				end
			end
			ST_READ: begin
				cell_d = mem_rd;
				fin    = 1'b1;
			end
			ST_HOLD: begin
				cell_d = cell_q;
				bad_d  = bad_q;
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_HOLD: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_CLEAR, ST_IDLE, ST_PRINT, ST_SCROLL, ST_READ: begin
				if (fin) begin
					state_d = slot_free ? ST_IDLE : ST_HOLD;
				end else if (go_print) begin
					state_d = ST_PRINT;
				end else if (go_scroll) begin
					state_d = ST_SCROLL;
				end else if (go_clear) begin
					state_d = ST_CLEAR;
				end else if (go_read) begin
					state_d = ST_READ;
				end else if (clr_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cols_q      <= RESET_COLUMNS;
			rows_q      <= RESET_ROWS;
			top_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			attr_q      <= RESET_ATTR;
			esc_q       <= 1'b0;
			cnt_q       <= '0;
			clr_q       <= '0;
			clr_rsp_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			top_q     <= top_d;
			col_q     <= col_d;
			row_q     <= row_d;
			attr_q    <= attr_d;
			esc_q     <= esc_d;
			cnt_q     <= cnt_d;
			clr_q     <= clr_d;
			clr_rsp_q <= clr_rsp_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_COLUMNS: cols_q <= cfg_data[COLS_W-1:0];
					CFG_ROWS:    rows_q <= cfg_data[ROWS_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		char_q <= char_d;
		cell_q <= cell_d;
		bad_q  <= bad_d;
		if (load) begin
			out_col_q  <= col_d;
			out_row_q  <= row_d;
			out_cell_q <= cell_d;
			out_bad_q  <= bad_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.cursor_col   = out_col_q;
	assign rsp.cursor_row   = out_row_q;
	assign rsp.cell_value   = out_cell_q;
	assign rsp.bad_position = out_bad_q;

`ifndef SYNTHESIS
	// a pending result holds a cursor inside the geometry in use
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ((rsp.cursor_row < r_eff && COLS_W'(rsp.cursor_col) < c_eff)
			|| (rsp.cursor_row == r_eff && rsp.cursor_col == '0)))
		else $error("cursor outside screen in result");

	// printing writes only cells of the visible area
	a_print_in_area: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PRINT && mem_we) |-> (row_q < r_eff && COLS_W'(col_q) < c_eff))
		else $error("print outside visible area");

	// read data is used only after a read was issued
	a_read_issued: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> $past(mem_re))
		else $error("cell read without store access");

	// no store write while an item is being taken
	a_no_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> !mem_we)
		else $error("store written while accepting an item");
`endif

endmodule
